// File: rtl/pau_pkg.sv
// ----------------------------------------------------------------------------
// pau_pkg
// Types, widths and coefficient tables shared by the polynomial activation
// unit and its pipeline sections.
// ----------------------------------------------------------------------------
package pau_pkg;

   // request and response field widths
   localparam int FUNC_W = 3;
   localparam int IN_W   = 16;
   localparam int Y_W    = 32;

   // fixed-point scales
   localparam int COEF_FRAC_BITS = 24;
   localparam int OUT_FRAC_BITS  = 16;

   // polynomial shape
   localparam int NUM_CODES = 8;
   localparam int NUM_TERMS = 6;
   localparam int COEF_W    = 25;

   // magnitudes of |x|^k, k = 1..5 (|x| <= 2^15)
   localparam int M1_W = 16;
   localparam int M2_W = 31;
   localparam int M3_W = 46;
   localparam int M4_W = 61;
   localparam int M5_W = 76;

   // coefficient products are cut into 32-bit slices of the power
   localparam int CHUNK_W    = 32;
   localparam int NUM_CHUNKS = 3;
   localparam int PW_W       = CHUNK_W * NUM_CHUNKS;
   localparam int PP_W       = COEF_W + CHUNK_W;
   localparam int MAG_W      = COEF_W + M5_W;

   // accumulator: holds the exact sum and the full output slice for any
   // fractional width of the argument from 8 to 14
   localparam int ACC_W = 112;

   // half an output LSB, in units of the constant term's scale
   localparam int ROUND_UNITS = 1 << (COEF_FRAC_BITS - OUT_FRAC_BITS - 1);

   // saturation limits
   localparam logic [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
   localparam logic [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

   // coefficient magnitudes in units of 2^-24, row per function code,
   // column per power of x
   localparam logic [COEF_W-1:0] COEF_MAG [NUM_CODES][NUM_TERMS] = '{
      '{25'd0,        25'd16777216, 25'd0,       25'd0,       25'd0,      25'd0},
      '{25'd16777216, 25'd0,        25'd0,       25'd0,       25'd0,      25'd0},
      '{25'd7885292,  25'd8388608,  25'd1509949, 25'd0,       25'd0,      25'd0},
      '{25'd8388608,  25'd3019899,  25'd0,       25'd0,       25'd0,      25'd0},
      '{25'd8388608,  25'd4194304,  25'd0,       25'd349525,  25'd0,      25'd34953},
      '{25'd4194304,  25'd0,        25'd1048576, 25'd0,       25'd174763, 25'd0},
      '{25'd0,        25'd16777216, 25'd0,       25'd5592405, 25'd0,      25'd2236962},
      '{25'd0,        25'd0,        25'd0,       25'd0,       25'd0,      25'd0}
   };

   // negative coefficients, bit k set for power k
   localparam logic [NUM_TERMS-1:0] COEF_NEG [NUM_CODES] = '{
      6'b000000,
      6'b000000,
      6'b000000,
      6'b000000,
      6'b001000,
      6'b000100,
      6'b001000,
      6'b000000
   };

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic signed [IN_W-1:0] x_in;
   } req_type;

   typedef struct packed {
      logic signed [Y_W-1:0] y_out;
      logic                  saturated;
   } rsp_type;

   // powers of |x| with the function code and argument sign
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              xneg;
      logic [M1_W-1:0]   m1;
      logic [M2_W-1:0]   m2;
      logic [M3_W-1:0]   m3;
      logic [M4_W-1:0]   m4;
      logic [M5_W-1:0]   m5;
   } pow_type;

   // signed terms at the common scale, constant term carries the rounding
   typedef struct packed {
      logic [NUM_TERMS-1:0][ACC_W-1:0] term;
   } term_type;

endpackage

// File: rtl/pau_powers.sv
// ----------------------------------------------------------------------------
// pau_powers
// Four-stage pipeline forming |x| and its powers up to the fifth.
// ----------------------------------------------------------------------------
module pau_powers (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pau_pkg::req_type  in_data,
   output logic              in_stall,
   output logic              out_valid,
   output pau_pkg::pow_type  out_data,
   input  logic              out_stall
);

   localparam int NSTG = 4;
   localparam int HI_W = pau_pkg::M4_W - pau_pkg::CHUNK_W;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] adv;

   pau_pkg::pow_type s1_ff, s1_in;
   pau_pkg::pow_type s2_ff, s2_in;
   pau_pkg::pow_type s3_ff, s3_in;
   pau_pkg::pow_type s4_ff, s4_in;
   logic [pau_pkg::CHUNK_W+pau_pkg::M1_W-1:0] p5lo_ff, p5lo_in;
   logic [HI_W+pau_pkg::M1_W-1:0]             p5hi_ff, p5hi_in;

   logic [2*pau_pkg::M1_W-1:0]               sq;
   logic [pau_pkg::M2_W+pau_pkg::M1_W-1:0]   cube;
   logic [2*pau_pkg::M2_W-1:0]               quad;
   logic [pau_pkg::M1_W-1:0]                 mag;

   // advance a stage when it is empty or its successor moves
   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || !out_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = in_valid;
      for (int i = 1; i < NSTG; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_data  = s4_ff;

   // stage 1: magnitude and square
   always_comb begin
      mag             = in_data.x_in[pau_pkg::IN_W-1] ?
                        pau_pkg::M1_W'(~in_data.x_in + 1'b1) :
                        pau_pkg::M1_W'(in_data.x_in);
      sq              = mag * mag;
      s1_in           = '0;
      s1_in.func      = in_data.func;
      s1_in.xneg      = in_data.x_in[pau_pkg::IN_W-1];
      s1_in.m1        = mag;
      s1_in.m2        = sq[pau_pkg::M2_W-1:0];
   end

   // stage 2: cube and fourth power
   always_comb begin
      cube     = s1_ff.m2 * s1_ff.m1;
      quad     = s1_ff.m2 * s1_ff.m2;
      s2_in    = s1_ff;
      s2_in.m3 = cube[pau_pkg::M3_W-1:0];
      s2_in.m4 = quad[pau_pkg::M4_W-1:0];
   end

   // stage 3: fifth power as two partial products
   always_comb begin
      s3_in   = s2_ff;
      p5lo_in = s2_ff.m4[pau_pkg::CHUNK_W-1:0] * s2_ff.m1;
      p5hi_in = s2_ff.m4[pau_pkg::M4_W-1:pau_pkg::CHUNK_W] * s2_ff.m1;
   end

   // stage 4: merge the partial products
   always_comb begin
      s4_in    = s3_ff;
      s4_in.m5 = pau_pkg::M5_W'({p5hi_ff, {pau_pkg::CHUNK_W{1'b0}}}) +
                 pau_pkg::M5_W'(p5lo_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_ff <= s1_in;
      end
      if (adv[1]) begin
         s2_ff <= s2_in;
      end
      if (adv[2]) begin
         s3_ff   <= s3_in;
         p5lo_ff <= p5lo_in;
         p5hi_ff <= p5hi_in;
      end
      if (adv[3]) begin
         s4_ff <= s4_in;
      end
   end

endmodule

// File: rtl/pau_terms.sv
// ----------------------------------------------------------------------------
// pau_terms
// Three-stage pipeline scaling each power by its coefficient and bringing
// every term, signed, to the common accumulator scale.
// ----------------------------------------------------------------------------
module pau_terms #(
   parameter int IN_FRAC_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pau_pkg::pow_type  in_data,
   output logic              in_stall,
   output logic              out_valid,
   output pau_pkg::term_type out_data,
   input  logic              out_stall
);

   localparam int NSTG = 3;
   localparam int NPOW = pau_pkg::NUM_TERMS - 1;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] adv;

   logic [pau_pkg::PW_W-1:0] pw [NPOW];

   // stage 1: coefficient partial products
   logic [pau_pkg::PP_W-1:0]   pp_ff [NPOW][pau_pkg::NUM_CHUNKS];
   logic [pau_pkg::PP_W-1:0]   pp_in [NPOW][pau_pkg::NUM_CHUNKS];
   logic [pau_pkg::COEF_W-1:0] c0_ff, c0_in;
   logic [NPOW-1:0]            tneg_ff, tneg_in;

   // stage 2: term magnitudes
   logic [pau_pkg::MAG_W-1:0]  mag_ff [NPOW];
   logic [pau_pkg::MAG_W-1:0]  mag_in [NPOW];
   logic [pau_pkg::COEF_W-1:0] c0_2_ff;
   logic [NPOW-1:0]            tneg_2_ff;

   // stage 3: signed, aligned terms
   pau_pkg::term_type term_ff, term_in;

   // advance a stage when it is empty or its successor moves
   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || !out_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = in_valid;
      for (int i = 1; i < NSTG; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_data  = term_ff;

   // stage 1: multiply each 32-bit slice of x^k by its coefficient
   always_comb begin
      pw[0] = pau_pkg::PW_W'(in_data.m1);
      pw[1] = pau_pkg::PW_W'(in_data.m2);
      pw[2] = pau_pkg::PW_W'(in_data.m3);
      pw[3] = pau_pkg::PW_W'(in_data.m4);
      pw[4] = pau_pkg::PW_W'(in_data.m5);
      for (int k = 0; k < NPOW; k++) begin
         for (int j = 0; j < pau_pkg::NUM_CHUNKS; j++) begin
            pp_in[k][j] = pw[k][j*pau_pkg::CHUNK_W +: pau_pkg::CHUNK_W] *
                          pau_pkg::COEF_MAG[in_data.func][k+1];
         end
         // odd powers of a negative argument flip the term sign
         tneg_in[k] = pau_pkg::COEF_NEG[in_data.func][k+1] ^
                      (in_data.xneg && ((k + 1) % 2 == 1));
      end
      c0_in = pau_pkg::COEF_MAG[in_data.func][0];
   end

   // stage 2: merge slices into the term magnitude
   always_comb begin
      for (int k = 0; k < NPOW; k++) begin
         mag_in[k] = pau_pkg::MAG_W'(pp_ff[k][0]) +
                     (pau_pkg::MAG_W'(pp_ff[k][1]) << pau_pkg::CHUNK_W) +
                     (pau_pkg::MAG_W'(pp_ff[k][2]) << (2 * pau_pkg::CHUNK_W));
      end
   end

   // stage 3: align to 2^-(24 + 5*frac) and apply sign; the constant term
   // also carries half an output LSB for rounding
   always_comb begin
      logic [pau_pkg::ACC_W-1:0] shifted;
      term_in.term[0] = pau_pkg::ACC_W'(pau_pkg::ACC_W'(c0_2_ff) +
                        pau_pkg::ACC_W'(pau_pkg::ROUND_UNITS)) <<
                        (NPOW * IN_FRAC_BITS);
      for (int k = 0; k < NPOW; k++) begin
         shifted = pau_pkg::ACC_W'(mag_ff[k]) << ((NPOW - 1 - k) * IN_FRAC_BITS);
         term_in.term[k+1] = tneg_2_ff[k] ? (~shifted + 1'b1) : shifted;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pp_ff   <= pp_in;
         c0_ff   <= c0_in;
         tneg_ff <= tneg_in;
      end
      if (adv[1]) begin
         mag_ff    <= mag_in;
         c0_2_ff   <= c0_ff;
         tneg_2_ff <= tneg_ff;
      end
      if (adv[2]) begin
         term_ff <= term_in;
      end
   end

endmodule

// File: rtl/pau_sum.sv
// ----------------------------------------------------------------------------
// pau_sum
// Four-stage pipeline summing the six terms, rounding to 2^-16 and
// saturating to a signed 32-bit result.
// ----------------------------------------------------------------------------
module pau_sum #(
   parameter int IN_FRAC_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pau_pkg::term_type in_data,
   output logic              in_stall,
   output logic              out_valid,
   output pau_pkg::rsp_type  out_data,
   input  logic              out_stall
);

   localparam int NSTG = 4;
   localparam int SH   = pau_pkg::COEF_FRAC_BITS - pau_pkg::OUT_FRAC_BITS +
                         (pau_pkg::NUM_TERMS - 1) * IN_FRAC_BITS;
   localparam int HI_W = pau_pkg::ACC_W - SH - pau_pkg::Y_W + 1;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] adv;

   logic [pau_pkg::ACC_W-1:0] p0_ff, p1_ff, p2_ff;
   logic [pau_pkg::ACC_W-1:0] a_ff, b_ff;
   logic [pau_pkg::ACC_W-1:0] tot_ff;
   pau_pkg::rsp_type          rsp_ff, rsp_in;

   logic [HI_W-1:0] hi;
   logic            fits;

   // advance a stage when it is empty or its successor moves
   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || !out_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = in_valid;
      for (int i = 1; i < NSTG; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_data  = rsp_ff;

   // stage 4: drop the fraction, check the upper bits, clamp
   always_comb begin
      hi   = tot_ff[pau_pkg::ACC_W-1:SH+pau_pkg::Y_W-1];
      fits = (&hi) || !(|hi);
      rsp_in.saturated = !fits;
      if (fits) begin
         rsp_in.y_out = tot_ff[SH+pau_pkg::Y_W-1:SH];
      end else if (tot_ff[pau_pkg::ACC_W-1]) begin
         rsp_in.y_out = pau_pkg::Y_MIN;
      end else begin
         rsp_in.y_out = pau_pkg::Y_MAX;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // adder tree and result register
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         p0_ff <= in_data.term[0] + in_data.term[1];
         p1_ff <= in_data.term[2] + in_data.term[3];
         p2_ff <= in_data.term[4] + in_data.term[5];
      end
      if (adv[1]) begin
         a_ff <= p0_ff + p1_ff;
         b_ff <= p2_ff;
      end
      if (adv[2]) begin
         tot_ff <= a_ff + b_ff;
      end
      if (adv[3]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: rtl/polynomial_activation_unit.sv
// ----------------------------------------------------------------------------
// polynomial_activation_unit
// Each request passes the powers, terms and sum sections in that order.
// Throughput: one request per cycle while the response side does not stall;
// the 11 register stages (powers, coefficient products, term alignment,
// adder tree) each take a new request.
// Reset clears every stage valid bit; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module polynomial_activation_unit #(
   parameter int IN_FRAC_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  pau_pkg::req_type req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output pau_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);

   logic              pow_valid;
   logic              pow_stall;
   pau_pkg::pow_type  pow_data;
   logic              term_valid;
   logic              term_stall;
   pau_pkg::term_type term_data;

   // powers of |x|
   pau_powers u_powers (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_stall  (req_stall),
      .out_valid (pow_valid),
      .out_data  (pow_data),
      .out_stall (pow_stall)
   );

   // coefficient scaling and alignment
   pau_terms #(
      .IN_FRAC_BITS (IN_FRAC_BITS)
   ) u_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pow_valid),
      .in_data   (pow_data),
      .in_stall  (pow_stall),
      .out_valid (term_valid),
      .out_data  (term_data),
      .out_stall (term_stall)
   );

   // sum, round and saturate
   pau_sum #(
      .IN_FRAC_BITS (IN_FRAC_BITS)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (term_valid),
      .in_data   (term_data),
      .in_stall  (term_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   // pipeline comes out of reset empty
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // without back-pressure at the output every stage moves
   assert property (@(posedge clock) disable iff (reset) !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   // a saturated response carries one of the clamp values
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
      (rsp_data.y_out == pau_pkg::Y_MAX || rsp_data.y_out == pau_pkg::Y_MIN))
      else $error("saturated response with unclamped value");

endmodule
